// ----- design/ktm_pkg.sv -----
// Package for the keyword table match block: payload structs, operation codes
// and default sizes. It has no dependencies. Every other design file uses it.
`default_nettype none

package ktm_pkg;

   // Default table sizes. The top level passes these down as parameters.
   localparam int MAX_KEYWORDS_DEF = 64;
   localparam int MAX_CHARS_DEF    = 8;

   // Field widths fixed by the interface
   localparam int SLOT_W   = 6;
   localparam int POSN_W   = 3;
   localparam int CHAR_W   = 8;
   localparam int LEN_W    = 4;
   localparam int COUNT_W  = 7;
   localparam int INDEX_W  = 6;

   // Operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic              operation;
      logic [SLOT_W-1:0] slot;
      logic [POSN_W-1:0] position;
      logic [CHAR_W-1:0] char_value;
      logic              last;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] match_index;
   } rsp_type;

   // Write request into the keyword table
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      logic [POSN_W-1:0] position;
      logic [CHAR_W-1:0] char_value;
      logic              last;
   } load_type;

endpackage

`default_nettype wire

// ----- design/ktm_table.sv -----
// Keyword table storage: byte-wide text memory and a length memory, one write
// port and one registered read port each. Depends on ktm_pkg.
`default_nettype none

module ktm_table #(
   parameter int MAX_KEYWORDS = ktm_pkg::MAX_KEYWORDS_DEF,
   parameter int MAX_CHARS    = ktm_pkg::MAX_CHARS_DEF,
   localparam int IDX_W = (MAX_KEYWORDS > 1) ? $clog2(MAX_KEYWORDS) : 1,
   localparam int POS_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1
) (
   input  wire logic                        clock,
   input  wire ktm_pkg::load_type           wr,
   input  wire logic [IDX_W-1:0]            rd_slot,
   input  wire logic [POS_W-1:0]            rd_pos,
   output logic [ktm_pkg::CHAR_W-1:0]       rd_char,
   output logic [ktm_pkg::LEN_W-1:0]        rd_len
);

   logic [ktm_pkg::CHAR_W-1:0] text_mem [MAX_KEYWORDS][MAX_CHARS];
   logic [ktm_pkg::LEN_W-1:0]  len_mem  [MAX_KEYWORDS];

   logic [ktm_pkg::CHAR_W-1:0] rd_char_ff;
   logic [ktm_pkg::LEN_W-1:0]  rd_len_ff;

   logic [IDX_W+ktm_pkg::SLOT_W-1:0] slot_x;
   logic [POS_W+ktm_pkg::POSN_W-1:0] pos_x;
   logic                             slot_ok;
   logic                             pos_ok;

   assign slot_x  = {{IDX_W{1'b0}}, wr.slot};
   assign pos_x   = {{POS_W{1'b0}}, wr.position};
   assign slot_ok = ({26'b0, wr.slot} < MAX_KEYWORDS);
   assign pos_ok  = ({29'b0, wr.position} < MAX_CHARS);

   // Drop loads aimed past the table; bytes past the last position are not stored
   always_ff @(posedge clock) begin
      if (wr.en && slot_ok) begin
         if (pos_ok) begin
            text_mem[slot_x[IDX_W-1:0]][pos_x[POS_W-1:0]] <= wr.char_value;
         end
         if (wr.last) begin
            len_mem[slot_x[IDX_W-1:0]] <= {1'b0, wr.position} + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_char_ff <= text_mem[rd_slot][rd_pos];
      rd_len_ff  <= len_mem[rd_slot];
   end

   assign rd_char = rd_char_ff;
   assign rd_len  = rd_len_ff;

endmodule

`default_nettype wire

// ----- design/ktm_search.sv -----
// Search sequencer: holds the query bytes, shifts them out one byte a cycle
// against the table read data, and walks the slots. Depends on ktm_pkg.
`default_nettype none

module ktm_search #(
   parameter int MAX_KEYWORDS = ktm_pkg::MAX_KEYWORDS_DEF,
   parameter int MAX_CHARS    = ktm_pkg::MAX_CHARS_DEF,
   localparam int IDX_W = (MAX_KEYWORDS > 1) ? $clog2(MAX_KEYWORDS) : 1,
   localparam int POS_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire ktm_pkg::req_type              req,
   input  wire logic [ktm_pkg::COUNT_W-1:0]   kw_count,
   input  wire logic [ktm_pkg::CHAR_W-1:0]    rd_char,
   input  wire logic [ktm_pkg::LEN_W-1:0]     rd_len,
   output logic [IDX_W-1:0]                   rd_slot,
   output logic [POS_W-1:0]                   rd_pos,
   output logic                               busy,
   output logic                               rsp_valid,
   output ktm_pkg::rsp_type                   rsp
);

   localparam int CUR_W = $clog2(MAX_KEYWORDS + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_PREP = 3'b010,
      ST_SCAN = 3'b100
   } state_type;

   state_type                  state_ff, state_in;
   logic [CUR_W-1:0]           cur_ff, cur_in;
   logic [POS_W-1:0]           byte_ff, byte_in;
   logic [ktm_pkg::LEN_W-1:0]  qlen_ff, qlen_in;
   logic [ktm_pkg::CHAR_W-1:0] qry_ff   [MAX_CHARS];
   logic [ktm_pkg::CHAR_W-1:0] shift_ff [MAX_CHARS];
   logic [ktm_pkg::CHAR_W-1:0] shift_in [MAX_CHARS];
   logic                       rsp_valid_ff;
   ktm_pkg::rsp_type           rsp_ff;

   logic [CUR_W-1:0]           limit;
   logic [CUR_W-1:0]           cur_nx;
   logic [CUR_W+5:0]           cur_x;
   logic [POS_W+2:0]           pos_x;
   logic                       pos_ok;
   logic                       too_long;
   logic                       len_ok;
   logic                       byte_ok;
   logic                       last_byte;
   logic                       done;
   logic                       hit;

   assign pos_x    = {{POS_W{1'b0}}, req.position};
   assign pos_ok   = ({29'b0, req.position} < MAX_CHARS);
   assign too_long = ({28'b0, qlen_ff} > MAX_CHARS);
   assign cur_nx   = cur_ff + 1'b1;
   assign cur_x    = {6'b0, cur_ff};
   assign len_ok   = (rd_len == qlen_ff);
   assign byte_ok  = (rd_char == shift_ff[0]);
   assign last_byte = ({{(ktm_pkg::LEN_W-POS_W){1'b0}}, byte_ff} == (qlen_ff - 4'd1));

   always_comb begin
      if ({25'b0, kw_count} > MAX_KEYWORDS) begin
         limit = CUR_W'(MAX_KEYWORDS);
      end else begin
         limit = CUR_W'(kw_count);
      end
   end

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      byte_in  = byte_ff;
      qlen_in  = qlen_ff;
      shift_in = shift_ff;
      rd_slot  = cur_ff[IDX_W-1:0];
      rd_pos   = byte_ff;
      done     = 1'b0;
      hit      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req.operation == ktm_pkg::OP_QUERY) && req.last) begin
               qlen_in  = {1'b0, req.position} + 4'd1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (too_long || (limit == '0)) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cur_in   = '0;
               byte_in  = '0;
               shift_in = qry_ff;
               rd_slot  = '0;
               rd_pos   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (((byte_ff == '0) && !len_ok) || !byte_ok) begin
               // Advance to the next slot, or give up at the end of the table
               if (cur_nx >= limit) begin
                  done     = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  cur_in   = cur_nx;
                  byte_in  = '0;
                  shift_in = qry_ff;
                  rd_slot  = cur_nx[IDX_W-1:0];
                  rd_pos   = '0;
               end
            end else if (last_byte) begin
               done     = 1'b1;
               hit      = 1'b1;
               state_in = ST_IDLE;
            end else begin
               byte_in = byte_ff + 1'b1;
               for (int i = 0; i < MAX_CHARS - 1; i++) begin
                  shift_in[i] = shift_ff[i+1];
               end
               shift_in[MAX_CHARS-1] = '0;
               rd_pos = byte_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         qlen_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= done;
         qlen_ff      <= qlen_in;
      end
   end

   // Query bytes start at zero and are overwritten one position at a time
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CHARS; i++) begin
            qry_ff[i] <= '0;
         end
      end else if (accept && (req.operation == ktm_pkg::OP_QUERY) && pos_ok) begin
         qry_ff[pos_x[POS_W-1:0]] <= req.char_value;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      byte_ff  <= byte_in;
      shift_ff <= shift_in;
      if (done) begin
         rsp_ff.found       <= hit;
         rsp_ff.match_index <= hit ? cur_x[5:0] : '0;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// ----- design/keyword_table_match_core.sv -----
// Top level of the keyword table match block: configuration register, table
// storage and search sequencer. Depends on ktm_pkg, ktm_table, ktm_search.
//
//   channel   ports                          handshake
//   -------   ----------------------------   ------------------------------------
//   request   req_start, busy, req_data      transfer when req_start && !busy
//   response  rsp_valid, rsp_data            one-cycle strobe, cannot be held off
//   config    csr_we, csr_wdata              write when csr_we, no read-back
//
// Load items and query items without the last flag give no result. A query with
// last set holds busy through a setup state and then walks the slots, up to
// kw_count capped at MAX_KEYWORDS: per slot it checks the length and compares
// the query byte-serially against the single table read port, moving to the
// next slot on a mismatch and stopping at the first full match.
// The response strobe rises in the same cycle in which busy falls; the next item
// may be taken during that cycle. Reset is synchronous and clears the sequencer
// and the query bytes; table contents stay undefined until loaded.
`default_nettype none

module keyword_table_match_core #(
   parameter int MAX_KEYWORDS = ktm_pkg::MAX_KEYWORDS_DEF,
   parameter int MAX_CHARS    = ktm_pkg::MAX_CHARS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_start,
   output logic                             busy,
   input  wire ktm_pkg::req_type            req_data,
   output logic                             rsp_valid,
   output ktm_pkg::rsp_type                 rsp_data,
   input  wire logic                        csr_we,
   input  wire logic [ktm_pkg::COUNT_W-1:0] csr_wdata
);

   localparam int IDX_W = (MAX_KEYWORDS > 1) ? $clog2(MAX_KEYWORDS) : 1;
   localparam int POS_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

   logic [ktm_pkg::COUNT_W-1:0] kw_count_ff;
   logic                        accept;
   ktm_pkg::load_type           load_wr;
   logic [IDX_W-1:0]            rd_slot;
   logic [POS_W-1:0]            rd_pos;
   logic [ktm_pkg::CHAR_W-1:0]  rd_char;
   logic [ktm_pkg::LEN_W-1:0]   rd_len;

   // Number of slots searched; software must write it only while idle (the block does not enforce this)
   always_ff @(posedge clock) begin
      if (reset) begin
         kw_count_ff <= '0;
      end else if (csr_we) begin
         kw_count_ff <= csr_wdata;
      end
   end

   assign accept = req_start && !busy;

   // Route load transfers straight into the table
   assign load_wr.en         = accept && (req_data.operation == ktm_pkg::OP_LOAD);
   assign load_wr.slot       = req_data.slot;
   assign load_wr.position   = req_data.position;
   assign load_wr.char_value = req_data.char_value;
   assign load_wr.last       = req_data.last;

   ktm_table #(
      .MAX_KEYWORDS (MAX_KEYWORDS),
      .MAX_CHARS    (MAX_CHARS)
   ) u_table (
      .clock   (clock),
      .wr      (load_wr),
      .rd_slot (rd_slot),
      .rd_pos  (rd_pos),
      .rd_char (rd_char),
      .rd_len  (rd_len)
   );

   ktm_search #(
      .MAX_KEYWORDS (MAX_KEYWORDS),
      .MAX_CHARS    (MAX_CHARS)
   ) u_search (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .kw_count  (kw_count_ff),
      .rd_char   (rd_char),
      .rd_len    (rd_len),
      .rd_slot   (rd_slot),
      .rd_pos    (rd_pos),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

endmodule

`default_nettype wire

// ----- design/ktm_checker.sv -----
// Port-level checker for keyword_table_match_core, attached by bind.
// Depends on ktm_pkg.
`default_nettype none

module ktm_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_start,
   input wire logic             busy,
   input wire ktm_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire ktm_pkg::rsp_type rsp_data
);

   // A query ending transfer always starts a search
   assert property (@(posedge clock) disable iff (reset)
      (req_start && !busy && (req_data.operation == ktm_pkg::OP_QUERY) && req_data.last)
      |=> busy)
      else $error("search did not start after final query byte");

   // A load transfer never produces a response
   assert property (@(posedge clock) disable iff (reset)
      (req_start && !busy && (req_data.operation == ktm_pkg::OP_LOAD))
      |=> (!busy && !rsp_valid))
      else $error("load transfer produced activity");

   // Every response follows a busy period
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a search");

   // Responses are single strobes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back response strobes");

   // A miss reports index zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |-> (rsp_data.match_index == '0))
      else $error("nonzero index on a miss");

endmodule

bind keyword_table_match_core ktm_checker u_ktm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_start (req_start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire
